// ----- hdl/arp_pkg.sv -----
// Shared constants, types and saturation helper for the aggregation
// restrict/prolongate coarse-vector block. No dependencies.
package arp_pkg;

    localparam int unsigned COARSE_ENTRIES = 1024;
    localparam int unsigned MAX_BLOCK      = 4;
    localparam int unsigned NUM_DAMP       = 4;
    localparam int unsigned NUM_REGS       = 6;

    localparam int unsigned STORE_AW = $clog2(COARSE_ENTRIES);
    localparam int unsigned AGG_W    = 10;
    localparam int unsigned COMP_W   = 2;
    localparam int unsigned BS_W     = 3;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned FACT_W   = 16;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned PADDR_W  = $clog2(NUM_REGS) + 2;
    localparam int unsigned REG_IW   = PADDR_W - 2;

    localparam int unsigned FULL_AW  = (AGG_W + BS_W > STORE_AW) ? (AGG_W + BS_W)
                                                                 : (STORE_AW + 1);

    localparam int unsigned FRAC_F   = 12;
    localparam int          ONE_Q12  = 1 << FRAC_F;
    localparam int          HALF_LSB = 1 << (FRAC_F - 1);

    localparam int unsigned WPROD_W  = 2 * FACT_W + 1;
    localparam int unsigned WEIGHT_W = WPROD_W - FRAC_F + 2;
    localparam int unsigned PROD_W   = VAL_W + WEIGHT_W;

    localparam logic [REG_IW-1:0] REG_BLOCK_SIZE   = REG_IW'(0);
    localparam logic [REG_IW-1:0] REG_AUTO_DAMPING = REG_IW'(1);
    localparam logic [REG_IW-1:0] REG_DAMP_C0      = REG_IW'(2);
    localparam logic [REG_IW-1:0] REG_DAMP_C1      = REG_IW'(3);
    localparam logic [REG_IW-1:0] REG_DAMP_C2      = REG_IW'(4);
    localparam logic [REG_IW-1:0] REG_DAMP_C3      = REG_IW'(5);

    localparam logic [BS_W-1:0]   BS_RESET         = BS_W'(1);
    localparam logic signed [FACT_W-1:0] DAMP_RESET = FACT_W'(ONE_Q12);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 2'd0,
        OP_RESTRICT = 2'd1,
        OP_READ     = 2'd2,
        OP_PROLONG  = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_WEIGHT = 6'b000100,
        ST_MULT   = 6'b001000,
        ST_SCALE  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        logic signed [VAL_W-1:0]  r;
        hi = PROD_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
        lo = ~hi;
        if (x > hi)
        begin
            r = hi[VAL_W-1:0];
        end
        else if (x < lo)
        begin
            r = lo[VAL_W-1:0];
        end
        else
        begin
            r = x[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/aggregate_restrict_prolong.sv -----
// Top level of the aggregation multigrid coarse-vector block: APB register
// file, item sequencer and datapath for Q4.12 damping factors. Depends on arp_pkg and arp_ram.
//
//  channel   direction  handshake            contents
//  in        into       in_valid/in_stall    operation, aggregate_index, component,
//                                            data_value, auto_factor
//  out       out of     out_valid/out_stall  result_value, address_error
//  apb       into       psel/penable/pready  block_size, auto_damping, damp_c0..3
//
// One item is in work at a time; write, restrict, read and rejected items pass
// through the fetch and done states, prolongate also through weight, mult and scale.
// These states follow from the store's registered read and the two multiplies.
// Reset restores the registers to their defaults; the store is not cleared.
// A stalled result waits in the output register while the next item runs.
module aggregate_restrict_prolong (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [arp_pkg::PADDR_W-1:0]            paddr,
    input  logic [arp_pkg::APB_DW-1:0]             pwdata,
    output logic [arp_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [arp_pkg::OP_W-1:0]               operation,
    input  logic [arp_pkg::AGG_W-1:0]              aggregate_index,
    input  logic [arp_pkg::COMP_W-1:0]             component,
    input  logic signed [arp_pkg::VAL_W-1:0]       data_value,
    input  logic signed [arp_pkg::FACT_W-1:0]      auto_factor,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [arp_pkg::VAL_W-1:0]       result_value,
    output logic                                   address_error
);

    logic [arp_pkg::BS_W-1:0]          block_size_reg;
    logic                              auto_damping_reg;
    logic signed [arp_pkg::FACT_W-1:0] damp_reg [arp_pkg::NUM_DAMP];

    arp_pkg::state_t state_reg;
    arp_pkg::state_t state_next;

    arp_pkg::op_t                          op_reg;
    logic [arp_pkg::COMP_W-1:0]            comp_reg;
    logic signed [arp_pkg::VAL_W-1:0]      fine_reg;
    logic signed [arp_pkg::FACT_W-1:0]     af_reg;
    logic                                  err_reg;
    logic [arp_pkg::STORE_AW-1:0]          addr_reg;
    logic signed [arp_pkg::VAL_W-1:0]      entry_reg;
    logic signed [arp_pkg::WPROD_W-1:0]    wprod_reg;
    logic signed [arp_pkg::WEIGHT_W-1:0]   weight_reg;
    logic signed [arp_pkg::PROD_W-1:0]     prod_reg;
    logic signed [arp_pkg::VAL_W-1:0]      res_reg;
    logic signed [arp_pkg::VAL_W-1:0]      res_next;

    logic                                  out_valid_reg;
    logic signed [arp_pkg::VAL_W-1:0]      result_reg;
    logic                                  error_reg;

    logic [arp_pkg::REG_IW-1:0]            reg_idx;
    logic                                  cfg_wr;
    logic                                  in_accept;
    logic                                  out_free;
    logic                                  bs_ok;
    logic                                  comp_ok;
    logic                                  addr_ok;
    logic [arp_pkg::FULL_AW-1:0]           full_addr;
    logic                                  err_next;

    logic                                  ram_we;
    logic signed [arp_pkg::VAL_W-1:0]      ram_wdata;
    logic [arp_pkg::VAL_W-1:0]             ram_rdata;

    logic signed [arp_pkg::FACT_W:0]       damp_off;
    logic signed [arp_pkg::WPROD_W-1:0]    wprod_next;
    logic signed [arp_pkg::WPROD_W-1:0]    wprod_rnd;
    logic signed [arp_pkg::WEIGHT_W-1:0]   auto_w;
    logic signed [arp_pkg::WEIGHT_W-1:0]   weight_next;
    logic signed [arp_pkg::PROD_W-1:0]     prod_next;
    logic signed [arp_pkg::PROD_W-1:0]     prod_rnd;
    logic signed [arp_pkg::VAL_W-1:0]      scaled;
    logic signed [arp_pkg::VAL_W-1:0]      restrict_sum;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[arp_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg   <= arp_pkg::BS_RESET;
            auto_damping_reg <= 1'b1;
            for (int i = 0; i < arp_pkg::NUM_DAMP; i++)
            begin
                damp_reg[i] <= arp_pkg::DAMP_RESET;
            end
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                arp_pkg::REG_BLOCK_SIZE:   block_size_reg   <= pwdata[arp_pkg::BS_W-1:0];
                arp_pkg::REG_AUTO_DAMPING: auto_damping_reg <= pwdata[0];
                arp_pkg::REG_DAMP_C0:      damp_reg[0]      <= pwdata[arp_pkg::FACT_W-1:0];
                arp_pkg::REG_DAMP_C1:      damp_reg[1]      <= pwdata[arp_pkg::FACT_W-1:0];
                arp_pkg::REG_DAMP_C2:      damp_reg[2]      <= pwdata[arp_pkg::FACT_W-1:0];
                arp_pkg::REG_DAMP_C3:      damp_reg[3]      <= pwdata[arp_pkg::FACT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            arp_pkg::REG_BLOCK_SIZE:   prdata = arp_pkg::APB_DW'(block_size_reg);
            arp_pkg::REG_AUTO_DAMPING: prdata = arp_pkg::APB_DW'(auto_damping_reg);
            arp_pkg::REG_DAMP_C0:      prdata = arp_pkg::APB_DW'(damp_reg[0]);
            arp_pkg::REG_DAMP_C1:      prdata = arp_pkg::APB_DW'(damp_reg[1]);
            arp_pkg::REG_DAMP_C2:      prdata = arp_pkg::APB_DW'(damp_reg[2]);
            arp_pkg::REG_DAMP_C3:      prdata = arp_pkg::APB_DW'(damp_reg[3]);
            default:                   prdata = '0;
        endcase
    end

    // Address generation and range check at the input transfer.
    assign in_stall  = (state_reg != arp_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign full_addr = arp_pkg::FULL_AW'(aggregate_index) * arp_pkg::FULL_AW'(block_size_reg)
                     + arp_pkg::FULL_AW'(component);
    assign bs_ok     = (block_size_reg != '0)
                    && (block_size_reg <= arp_pkg::BS_W'(arp_pkg::MAX_BLOCK));
    assign comp_ok   = (arp_pkg::BS_W'(component) < block_size_reg);
    assign addr_ok   = (full_addr < arp_pkg::FULL_AW'(arp_pkg::COARSE_ENTRIES));
    assign err_next  = !(bs_ok && comp_ok && addr_ok);

    arp_ram #(
        .WIDTH(arp_pkg::VAL_W),
        .DEPTH(arp_pkg::COARSE_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (ram_wdata),
        .rd_en   (in_accept),
        .rd_addr (full_addr[arp_pkg::STORE_AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Datapath.
    assign restrict_sum = arp_pkg::sat_val(arp_pkg::PROD_W'(signed'(ram_rdata))
                                         + arp_pkg::PROD_W'(fine_reg));
    assign ram_we    = (state_reg == arp_pkg::ST_FETCH) && !err_reg
                    && ((op_reg == arp_pkg::OP_WRITE) || (op_reg == arp_pkg::OP_RESTRICT));
    assign ram_wdata = (op_reg == arp_pkg::OP_WRITE) ? fine_reg : restrict_sum;

    assign damp_off   = {damp_reg[0][arp_pkg::FACT_W-1], damp_reg[0]}
                      - (arp_pkg::FACT_W+1)'(arp_pkg::ONE_Q12);
    assign wprod_next = arp_pkg::WPROD_W'(damp_off) * arp_pkg::WPROD_W'(af_reg);

    assign wprod_rnd  = wprod_reg + arp_pkg::WPROD_W'(arp_pkg::HALF_LSB);
    assign auto_w     = arp_pkg::WEIGHT_W'(2 * arp_pkg::ONE_Q12)
                      - arp_pkg::WEIGHT_W'(damp_reg[0])
                      + arp_pkg::WEIGHT_W'(wprod_rnd >>> arp_pkg::FRAC_F);
    assign weight_next = ((block_size_reg == arp_pkg::BS_W'(1)) && auto_damping_reg)
                       ? auto_w : arp_pkg::WEIGHT_W'(damp_reg[comp_reg]);

    assign prod_next = arp_pkg::PROD_W'(entry_reg) * arp_pkg::PROD_W'(weight_reg);
    assign prod_rnd  = prod_reg + arp_pkg::PROD_W'(arp_pkg::HALF_LSB);
    assign scaled    = arp_pkg::sat_val(prod_rnd >>> arp_pkg::FRAC_F);

    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            arp_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = arp_pkg::ST_FETCH;
                end
            end
            arp_pkg::ST_FETCH:
            begin
                res_next   = '0;
                state_next = arp_pkg::ST_DONE;
                if (!err_reg)
                begin
                    unique case (op_reg)
                        arp_pkg::OP_WRITE:    res_next = '0;
                        arp_pkg::OP_RESTRICT: res_next = '0;
                        arp_pkg::OP_READ:     res_next = signed'(ram_rdata);
                        arp_pkg::OP_PROLONG:  state_next = arp_pkg::ST_WEIGHT;
                    endcase
                end
            end
            arp_pkg::ST_WEIGHT:
            begin
                state_next = arp_pkg::ST_MULT;
            end
            arp_pkg::ST_MULT:
            begin
                state_next = arp_pkg::ST_SCALE;
            end
            arp_pkg::ST_SCALE:
            begin
                res_next   = arp_pkg::sat_val(arp_pkg::PROD_W'(fine_reg)
                                            + arp_pkg::PROD_W'(scaled));
                state_next = arp_pkg::ST_DONE;
            end
            arp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = arp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == arp_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= arp_pkg::op_t'(operation);
            comp_reg <= component;
            fine_reg <= data_value;
            af_reg   <= auto_factor;
            err_reg  <= err_next;
            addr_reg <= full_addr[arp_pkg::STORE_AW-1:0];
        end
        if (state_reg == arp_pkg::ST_FETCH)
        begin
            entry_reg <= signed'(ram_rdata);
            wprod_reg <= wprod_next;
        end
        if (state_reg == arp_pkg::ST_WEIGHT)
        begin
            weight_reg <= weight_next;
        end
        if (state_reg == arp_pkg::ST_MULT)
        begin
            prod_reg <= prod_next;
        end
        res_reg <= res_next;
        if ((state_reg == arp_pkg::ST_DONE) && out_free)
        begin
            result_reg <= res_reg;
            error_reg  <= err_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = result_reg;
    assign address_error = error_reg;

endmodule

// ----- hdl/arp_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
module arp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/arp_checker.sv -----
// Port-level checks for aggregate_restrict_prolong, bound to the top level.
// Depends on the top level's port list only.
module arp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_value,
    input logic        address_error
);

    // Only one item is in work, so the input stalls while it is fetched.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input taken again while an item was in work");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && address_error |-> result_value == '0)
        else $error("rejected item returned a nonzero value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
                                   && $stable(address_error))
        else $error("stalled result changed or was dropped");

endmodule

bind aggregate_restrict_prolong arp_checker u_arp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_value  (result_value),
    .address_error (address_error)
);
